// ===== src/czr_pkg.sv =====
// Shared types, constants and arithmetic helpers of the centre-zoom resampler.
package czr_pkg;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 512;
  localparam int unsigned XBITS      = $clog2(MAX_WIDTH);
  localparam int unsigned YBITS      = $clog2(MAX_HEIGHT);
  localparam int unsigned BANK_ABITS = XBITS + YBITS - 2;
  localparam int unsigned BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  typedef struct packed {
    logic        op;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [23:0] rgb;
  } req_t;

  // Per axis: which neighbour lands in each parity bank, and its weight.
  typedef struct packed {
    logic [1:0]      ok;
    logic [1:0][7:0] addr;
    logic            par;
    logic [16:0]     wl;
  } axis_t;

  typedef struct packed {
    req_t             req;
    logic [3:0]       ok;
    logic [3:0][15:0] addr;
    logic             xpar;
    logic             ypar;
    logic [16:0]      wx;
    logic [16:0]      wy;
  } fetch_t;

  typedef struct packed {
    logic [8:0]       col;
    logic [8:0]       row;
    logic [3:0][23:0] pix;
    logic             xpar;
    logic             ypar;
    logic [16:0]      wx;
    logic [16:0]      wy;
  } taps_t;

  function automatic logic [7:0] mix8(input logic [7:0] l, input logic [7:0] r,
                                      input logic [16:0] wl);
    logic [25:0] s;
    logic [9:0]  v;
    s = {9'd0, l} * {9'd0, wl} + {9'd0, r} * {9'd0, WEIGHT_ONE - wl} + 26'd32768;
    v = s[25:16];
    return (v > 10'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [23:0] mix24(input logic [23:0] l, input logic [23:0] r,
                                        input logic [16:0] wl);
    return {mix8(l[23:16], r[23:16], wl), mix8(l[15:8], r[15:8], wl),
            mix8(l[7:0], r[7:0], wl)};
  endfunction

endpackage

// ===== src/czr_coord.sv =====
// Source point arithmetic: offset, scale multiply, then neighbour and bank address.
module czr_coord (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  czr_pkg::req_t       in_req,
  input  logic [9:0]          image_width,
  input  logic [9:0]          image_height,
  input  logic [23:0]         inv_scale,
  input  logic                interp_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output czr_pkg::fetch_t     out_fetch
);

  logic                 v0, v1;
  czr_pkg::req_t        req0, req1;
  logic signed [11:0]   dx0, dy0;
  logic signed [36:0]   mx1, my1;
  logic                 rdy0, rdy1, rdy2;
  czr_pkg::axis_t       ax, ay;
  czr_pkg::fetch_t      f_next;

  function automatic czr_pkg::axis_t axis_eval(input logic signed [36:0] m,
                                               input logic [9:0] n, input logic mode,
                                               input int unsigned lim);
    czr_pkg::axis_t       a;
    logic signed [37:0]   p17, px, pabs, rnd;
    logic signed [21:0]   xn, x0, xb, xs;
    logic [21:0]          mag;
    p17  = {m[36], m} + $signed({12'd0, n, 16'd0});
    px   = p17 >>> 1;
    pabs = px[37] ? -px : px;
    rnd  = pabs + 38'sd32768;
    mag  = rnd[37:16];
    xn   = px[37] ? -$signed(mag) : $signed(mag);
    if (mode == czr_pkg::MODE_NEAREST) begin
      x0   = xn;
      a.wl = czr_pkg::WEIGHT_ONE;
    end else begin
      x0   = px[37:16];
      a.wl = czr_pkg::WEIGHT_ONE - {1'b0, px[15:0]};
    end
    xb    = x0 + 22'sd1;
    a.par = x0[0];
    for (int b = 0; b < 2; b++) begin
      xs = (x0[0] == b[0]) ? x0 : xb;
      a.ok[b]   = !xs[21] && (xs[20:0] < {11'd0, n}) && (xs[20:0] < 21'(lim));
      a.addr[b] = xs[8:1];
    end
    return a;
  endfunction

  assign rdy2 = !out_valid || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_valid;
    end
    if (rdy0) begin
      req0 <= in_req;
      dx0  <= $signed({2'b0, in_req.col, 1'b0}) - $signed({2'b0, image_width});
      dy0  <= $signed({2'b0, in_req.row, 1'b0}) - $signed({2'b0, image_height});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1) begin
      req1 <= req0;
      mx1  <= 37'(dx0 * $signed({1'b0, inv_scale}));
      my1  <= 37'(dy0 * $signed({1'b0, inv_scale}));
    end
  end

  always_comb begin
    ax = axis_eval(mx1, image_width, interp_mode, czr_pkg::MAX_WIDTH);
    ay = axis_eval(my1, image_height, interp_mode, czr_pkg::MAX_HEIGHT);
    f_next.req  = req1;
    f_next.xpar = ax.par;
    f_next.ypar = ay.par;
    f_next.wx   = ax.wl;
    f_next.wy   = ay.wl;
    for (int k = 0; k < 4; k++) begin
      f_next.ok[k]   = ax.ok[k % 2] && ay.ok[k / 2];
      f_next.addr[k] = {ay.addr[k / 2], ax.addr[k % 2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
    if (rdy2) begin
      out_fetch <= f_next;
    end
  end

endmodule

// ===== src/czr_store.sv =====
// Frame store in four banks split by column and row parity, one read each per beat.
module czr_store (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  czr_pkg::fetch_t  in_fetch,
  output logic             out_valid,
  input  logic             out_ready,
  output czr_pkg::taps_t   out_taps
);

  logic                      v;
  logic                      op;
  logic [3:0]                ok;
  logic [23:0]               rd [4];
  logic [8:0]                col, row;
  logic                      xpar, ypar;
  logic [16:0]               wx, wy;
  logic                      adv;
  logic [1:0]                wbank;
  logic [15:0]               waddr;

  // Write beats retire here; only requests go on to the blend stages.
  assign out_valid = v && (op == czr_pkg::OP_REQUEST);
  assign adv       = !v || (op == czr_pkg::OP_WRITE) || out_ready;
  assign in_ready  = adv;
  assign wbank     = {in_fetch.req.row[0], in_fetch.req.col[0]};
  assign waddr     = {in_fetch.req.row[8:1], in_fetch.req.col[8:1]};

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [23:0] mem [czr_pkg::BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (adv && in_valid && in_fetch.req.op == czr_pkg::OP_WRITE && wbank == 2'(k)) begin
        mem[waddr] <= in_fetch.req.rgb;
      end
      if (adv) begin
        rd[k] <= mem[in_fetch.addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= in_valid;
    end
    if (adv) begin
      op   <= in_fetch.req.op;
      ok   <= in_fetch.ok;
      col  <= in_fetch.req.col;
      row  <= in_fetch.req.row;
      xpar <= in_fetch.xpar;
      ypar <= in_fetch.ypar;
      wx   <= in_fetch.wx;
      wy   <= in_fetch.wy;
    end
  end

  always_comb begin
    out_taps.col  = col;
    out_taps.row  = row;
    out_taps.xpar = xpar;
    out_taps.ypar = ypar;
    out_taps.wx   = wx;
    out_taps.wy   = wy;
    for (int k = 0; k < 4; k++) begin
      out_taps.pix[k] = ok[k] ? rd[k] : 24'd0;
    end
  end

endmodule

// ===== src/czr_blend.sv =====
// Horizontal blend of both rows, then the vertical blend into the output register.
module czr_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  czr_pkg::taps_t  in_taps,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [8:0]      out_col,
  output logic [8:0]      out_row,
  output logic [23:0]     out_rgb
);

  logic        v4;
  logic [8:0]  col4, row4;
  logic [23:0] c0, c1;
  logic [16:0] wy4;
  logic        rdy4, rdy5;
  logic [1:0]  i00, i10, i01, i11;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign in_ready = rdy4;

  assign i00 = {in_taps.ypar, in_taps.xpar};
  assign i10 = {in_taps.ypar, !in_taps.xpar};
  assign i01 = {!in_taps.ypar, in_taps.xpar};
  assign i11 = {!in_taps.ypar, !in_taps.xpar};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= in_valid;
    end
    if (rdy4) begin
      col4 <= in_taps.col;
      row4 <= in_taps.row;
      wy4  <= in_taps.wy;
      c0   <= czr_pkg::mix24(in_taps.pix[i00], in_taps.pix[i10], in_taps.wx);
      c1   <= czr_pkg::mix24(in_taps.pix[i01], in_taps.pix[i11], in_taps.wx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy5) begin
      out_valid <= v4;
    end
    if (rdy5) begin
      out_col <= col4;
      out_row <= row4;
      out_rgb <= czr_pkg::mix24(c0, c1, wy4);
    end
  end

endmodule

// ===== src/center_zoom_image_resampler.sv =====
// Top level of the centre-zoom resampler: configuration registers and pipeline.
//
// Input beats carry either a pixel write (operation 0) or an output pixel
// request (operation 1); both use in_valid/in_ready. Writes fill the frame
// store and give no result. Each request gives one beat on out_valid/out_ready
// with the requested column and row and the resampled colour.
// The configuration port writes one register per cycle with cfg_write high;
// it is to be written only while no beat is in flight, and the block itself
// does not enforce this. A request passes six register stages before its
// result shows on out_valid.
// Throughput is one beat per cycle while the receiver does not stall: the
// frame store is four banks split by column and row parity, so the four
// bilinear neighbours are read together, one read port per bank.
// Every stage holds its beat while the next is full, so a stalled receiver
// fills the pipeline and only then drops in_ready; bubbles close up.
// Synchronous reset clears the pipeline and loads the register defaults
// (width and height 512, unit scale, nearest mode). The frame store is not
// cleared and must be loaded before it is read.
module center_zoom_image_resampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [8:0]  col,
  input  logic [8:0]  row,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_col,
  output logic [8:0]  out_row,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [9:0]       image_width;
  logic [9:0]       image_height;
  logic [23:0]      inv_scale;
  logic             interp_mode;
  czr_pkg::req_t    req;
  logic             f_valid, f_ready, t_valid, t_ready;
  czr_pkg::fetch_t  fetch;
  czr_pkg::taps_t   taps;
  logic [23:0]      rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 10'd512;
      image_height <= 10'd512;
      inv_scale    <= 24'd65536;
      interp_mode  <= czr_pkg::MODE_NEAREST;
    end else if (cfg_write && !cfg_index[2]) begin
      case (cfg_index[1:0])
        czr_pkg::REG_WIDTH:  image_width  <= cfg_data[9:0];
        czr_pkg::REG_HEIGHT: image_height <= cfg_data[9:0];
        czr_pkg::REG_SCALE:  inv_scale    <= cfg_data;
        czr_pkg::REG_MODE:   interp_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign req = '{op: operation, col: col, row: row, rgb: {in_red, in_green, in_blue}};

  czr_coord u_coord (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(req),
    .image_width(image_width), .image_height(image_height),
    .inv_scale(inv_scale), .interp_mode(interp_mode),
    .out_valid(f_valid), .out_ready(f_ready), .out_fetch(fetch)
  );

  czr_store u_store (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_fetch(fetch),
    .out_valid(t_valid), .out_ready(t_ready), .out_taps(taps)
  );

  czr_blend u_blend (
    .clk(clk), .rst(rst),
    .in_valid(t_valid), .in_ready(t_ready), .in_taps(taps),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_col(out_col), .out_row(out_row), .out_rgb(rgb)
  );

  assign out_red   = rgb[23:16];
  assign out_green = rgb[15:8];
  assign out_blue  = rgb[7:0];

  // An empty output register lets every stage move, so input is taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with an empty output stage");

  // Nearest mode gives full weight to the one chosen source pixel.
  a_nearest_weight: assert property (@(posedge clk) disable iff (rst)
    f_valid && interp_mode == czr_pkg::MODE_NEAREST
    |-> fetch.wx == czr_pkg::WEIGHT_ONE && fetch.wy == czr_pkg::WEIGHT_ONE)
    else $error("nearest mode produced a fractional weight");

  // A write beat never reaches the blend stages.
  a_write_retires: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> u_store.op == czr_pkg::OP_REQUEST)
    else $error("write beat passed the frame store");

endmodule
